// File: rtl/tdip_pkg.sv
`default_nettype none

package tdip_pkg;

	localparam int FIELD_W = 24;
	localparam int PROD_W = 2 * FIELD_W;
	localparam int NORM_W = 48;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = 48;
	localparam int HALF_W = MAG_W / 2;
	localparam int SCALE_W = 20;
	localparam int PART_W = HALF_W + SCALE_W;
	localparam int NUM_W = MAG_W + SCALE_W;
	localparam int DIP_W = 32;
	localparam int LANES = 3;
	localparam int PRE_STAGES = 6;
	localparam int NSTAGE = PRE_STAGES + DIP_W;

	localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(1000000);
	localparam logic [DIP_W-1:0] DIP_MAX = {1'b0, {(DIP_W-1){1'b1}}};
	localparam logic [DIP_W-1:0] DIP_MIN = {1'b1, {(DIP_W-1){1'b0}}};

	typedef struct packed {
		logic neg;
		logic ovf;
		logic [MAG_W-1:0] rem;
		logic [DIP_W-1:0] lo;
		logic [DIP_W-1:0] q;
	} lane_t;

	typedef struct packed {
		logic signed [DIP_W-1:0] dipole_x;
		logic signed [DIP_W-1:0] dipole_y;
		logic signed [DIP_W-1:0] dipole_z;
		logic weak_field;
		logic saturated;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/tdip_if.sv
`default_nettype none

interface tdip_in_if;
	logic valid;
	logic ready;
	logic signed [tdip_pkg::FIELD_W-1:0] field_x;
	logic signed [tdip_pkg::FIELD_W-1:0] field_y;
	logic signed [tdip_pkg::FIELD_W-1:0] field_z;
	logic signed [tdip_pkg::FIELD_W-1:0] torque_x;
	logic signed [tdip_pkg::FIELD_W-1:0] torque_y;
	logic signed [tdip_pkg::FIELD_W-1:0] torque_z;

	modport source(output valid, field_x, field_y, field_z, torque_x, torque_y, torque_z,
		input ready);
	modport sink(input valid, field_x, field_y, field_z, torque_x, torque_y, torque_z,
		output ready);
endinterface

interface tdip_out_if;
	logic valid;
	logic ready;
	logic signed [tdip_pkg::DIP_W-1:0] dipole_x;
	logic signed [tdip_pkg::DIP_W-1:0] dipole_y;
	logic signed [tdip_pkg::DIP_W-1:0] dipole_z;
	logic weak_field;
	logic saturated;

	modport source(output valid, dipole_x, dipole_y, dipole_z, weak_field, saturated,
		input ready);
	modport sink(input valid, dipole_x, dipole_y, dipole_z, weak_field, saturated,
		output ready);
endinterface

`default_nettype wire

// File: rtl/torque_to_magnetic_dipole.sv
`default_nettype none

// Channel    Dir   Handshake        Word
// req        in    valid/ready      field_x/y/z, torque_x/y/z (24 bit signed)
// rsp        out   valid/ready      dipole_x/y/z (32 bit signed), weak_field, saturated
// cfg        in    cfg_wen          cfg_wdata = min_field_norm_sq (48 bit)
//
// One word is accepted per cycle while the skid register is empty.
// The restoring divider resolves one quotient bit per stage.
// Reset clears the valid bits, the output and skid registers, and the threshold.
// A stall on rsp fills a one-word skid register and then freezes the whole pipeline.

module torque_to_magnetic_dipole (
	input wire logic clk,
	input wire logic arst_n,
	tdip_in_if.sink req,
	tdip_out_if.source rsp,
	input wire logic cfg_wen,
	input wire logic [tdip_pkg::NORM_W-1:0] cfg_wdata
);

	localparam int NST = tdip_pkg::NSTAGE;
	localparam int NDIV = tdip_pkg::DIP_W;

	logic [tdip_pkg::NORM_W-1:0] thr_q;
	logic [NST-1:0] vld_q;
	logic adv;

	logic signed [tdip_pkg::PROD_W-1:0] sq_s1 [tdip_pkg::LANES];
	logic signed [tdip_pkg::PROD_W-1:0] pa_s1 [tdip_pkg::LANES];
	logic signed [tdip_pkg::PROD_W-1:0] pb_s1 [tdip_pkg::LANES];

	logic [tdip_pkg::NORM_W-1:0] n_s2;
	logic signed [tdip_pkg::CROSS_W-1:0] cr_s2 [tdip_pkg::LANES];

	logic [tdip_pkg::NORM_W-1:0] n_s3;
	logic weak_s3;
	logic neg_s3 [tdip_pkg::LANES];
	logic [tdip_pkg::MAG_W-1:0] mag_s3 [tdip_pkg::LANES];

	logic [tdip_pkg::NORM_W-1:0] n_s4;
	logic weak_s4;
	logic neg_s4 [tdip_pkg::LANES];
	logic [tdip_pkg::PART_W-1:0] pl_s4 [tdip_pkg::LANES];
	logic [tdip_pkg::PART_W-1:0] ph_s4 [tdip_pkg::LANES];

	logic [tdip_pkg::NORM_W-1:0] n_s5;
	logic weak_s5;
	logic neg_s5 [tdip_pkg::LANES];
	logic [tdip_pkg::NUM_W-1:0] num_s5 [tdip_pkg::LANES];

	// Index 0 is stage 6; index k holds the word after k quotient bits.
	tdip_pkg::lane_t dv_s6 [NDIV+1][tdip_pkg::LANES];
	logic [tdip_pkg::NORM_W-1:0] nrm_s6 [NDIV+1];
	logic weak_s6 [NDIV+1];

	tdip_pkg::res_t res;
	tdip_pkg::res_t out_q;
	tdip_pkg::res_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic out_free;

	assign adv = !skid_v_q;
	assign req.ready = adv;
	assign out_free = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1[0] <= req.field_x * req.field_x;
			sq_s1[1] <= req.field_y * req.field_y;
			sq_s1[2] <= req.field_z * req.field_z;
			pa_s1[0] <= req.field_y * req.torque_z;
			pb_s1[0] <= req.field_z * req.torque_y;
			pa_s1[1] <= req.field_z * req.torque_x;
			pb_s1[1] <= req.field_x * req.torque_z;
			pa_s1[2] <= req.field_x * req.torque_y;
			pb_s1[2] <= req.field_y * req.torque_x;

			n_s2 <= $unsigned(sq_s1[0]) + $unsigned(sq_s1[1]) + $unsigned(sq_s1[2]);
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				cr_s2[i] <= tdip_pkg::CROSS_W'(pa_s1[i]) - tdip_pkg::CROSS_W'(pb_s1[i]);
			end

			n_s3 <= n_s2;
			weak_s3 <= (n_s2 <= thr_q) || (n_s2 == '0);
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				neg_s3[i] <= cr_s2[i][tdip_pkg::CROSS_W-1];
				mag_s3[i] <= cr_s2[i][tdip_pkg::CROSS_W-1]
					? tdip_pkg::MAG_W'(-cr_s2[i]) : tdip_pkg::MAG_W'(cr_s2[i]);
			end

			n_s4 <= n_s3;
			weak_s4 <= weak_s3;
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				neg_s4[i] <= neg_s3[i];
				pl_s4[i] <= mag_s3[i][tdip_pkg::HALF_W-1:0] * tdip_pkg::SCALE;
				ph_s4[i] <= mag_s3[i][tdip_pkg::MAG_W-1:tdip_pkg::HALF_W] * tdip_pkg::SCALE;
			end

			n_s5 <= n_s4;
			weak_s5 <= weak_s4;
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				neg_s5[i] <= neg_s4[i];
				num_s5[i] <= tdip_pkg::NUM_W'(pl_s4[i])
					+ {ph_s4[i], {tdip_pkg::HALF_W{1'b0}}};
			end

			nrm_s6[0] <= n_s5;
			weak_s6[0] <= weak_s5;
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				dv_s6[0][i].neg <= neg_s5[i];
				dv_s6[0][i].ovf <= tdip_pkg::NORM_W'(num_s5[i][tdip_pkg::NUM_W-1:NDIV]) >= n_s5;
				dv_s6[0][i].rem <= tdip_pkg::MAG_W'(num_s5[i][tdip_pkg::NUM_W-1:NDIV]);
				dv_s6[0][i].lo <= num_s5[i][NDIV-1:0];
				dv_s6[0][i].q <= '0;
			end
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [tdip_pkg::MAG_W:0] trial [tdip_pkg::LANES];
		logic ge [tdip_pkg::LANES];

		always_comb begin
			for (int i = 0; i < tdip_pkg::LANES; i++) begin
				trial[i] = {dv_s6[k][i].rem, dv_s6[k][i].lo[NDIV-1]};
				ge[i] = trial[i] >= {1'b0, nrm_s6[k]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nrm_s6[k+1] <= nrm_s6[k];
				weak_s6[k+1] <= weak_s6[k];
				for (int i = 0; i < tdip_pkg::LANES; i++) begin
					dv_s6[k+1][i].neg <= dv_s6[k][i].neg;
					dv_s6[k+1][i].ovf <= dv_s6[k][i].ovf;
					dv_s6[k+1][i].rem <= ge[i]
						? tdip_pkg::MAG_W'(trial[i] - {1'b0, nrm_s6[k]})
						: trial[i][tdip_pkg::MAG_W-1:0];
					dv_s6[k+1][i].lo <= {dv_s6[k][i].lo[NDIV-2:0], 1'b0};
					dv_s6[k+1][i].q <= {dv_s6[k][i].q[NDIV-2:0], ge[i]};
				end
			end
		end
	end

	always_comb begin
		logic [tdip_pkg::DIP_W-1:0] val [tdip_pkg::LANES];
		logic sat [tdip_pkg::LANES];
		tdip_pkg::lane_t ln;
		for (int i = 0; i < tdip_pkg::LANES; i++) begin
			ln = dv_s6[NDIV][i];
			if (ln.neg) begin
				sat[i] = ln.ovf || (ln.q > tdip_pkg::DIP_MIN);
				val[i] = sat[i] ? tdip_pkg::DIP_MIN : -ln.q;
			end else begin
				sat[i] = ln.ovf || ln.q[tdip_pkg::DIP_W-1];
				val[i] = sat[i] ? tdip_pkg::DIP_MAX : ln.q;
			end
		end
		if (weak_s6[NDIV]) begin
			res = '0;
			res.weak_field = 1'b1;
		end else begin
			res.dipole_x = $signed(val[0]);
			res.dipole_y = $signed(val[1]);
			res.dipole_z = $signed(val[2]);
			res.weak_field = 1'b0;
			res.saturated = sat[0] || sat[1] || sat[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			out_q <= '0;
			skid_q <= '0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else if (vld_q[NST-1]) begin
				out_q <= res;
				out_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b0;
			end
		end else if (adv && vld_q[NST-1]) begin
			skid_q <= res;
			skid_v_q <= 1'b1;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.dipole_x = out_q.dipole_x;
	assign rsp.dipole_y = out_q.dipole_y;
	assign rsp.dipole_z = out_q.dipole_z;
	assign rsp.weak_field = out_q.weak_field;
	assign rsp.saturated = out_q.saturated;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a word while the output register is empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NST-1] && adv && out_v_q && !rsp.ready) |=> skid_v_q)
		else $error("word leaving the pipeline during a stall was not caught");

	a_weak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.weak_field) |->
		(out_q.dipole_x == '0 && out_q.dipole_y == '0 && out_q.dipole_z == '0
		&& !out_q.saturated))
		else $error("weak field result carries a nonzero dipole or saturation");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.saturated) |->
		($unsigned(out_q.dipole_x) == tdip_pkg::DIP_MAX
		|| $unsigned(out_q.dipole_x) == tdip_pkg::DIP_MIN
		|| $unsigned(out_q.dipole_y) == tdip_pkg::DIP_MAX
		|| $unsigned(out_q.dipole_y) == tdip_pkg::DIP_MIN
		|| $unsigned(out_q.dipole_z) == tdip_pkg::DIP_MAX
		|| $unsigned(out_q.dipole_z) == tdip_pkg::DIP_MIN))
		else $error("saturated flag set with no component at a limit");

endmodule

`default_nettype wire
